[rtl/core/rtrs_pkg.sv]
// ----------------------------------------------------------------------------
// rtrs_pkg
// Shared constants and types for the rectangle top-k rank selector.
// ----------------------------------------------------------------------------
package rtrs_pkg;

  localparam int MAX_KEEP   = 32;
  localparam int SLOT_W     = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W      = $clog2(MAX_KEEP + 1);

  localparam int ID_W       = 32;
  localparam int RANK_W     = 31;
  localparam int CRD_W      = 32;
  localparam int KEEP_W     = 6;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_CNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_MODE = 3'd5;

  localparam logic [MODE_W-1:0] MODE_X_ONLY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_Y_ONLY = 2'd2;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd20;

  typedef struct packed {
    logic              [ID_W-1:0]   id;
    logic              [RANK_W-1:0] rank;
    logic              [CRD_W-1:0]  x;
    logic              [CRD_W-1:0]  y;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   hit;
    logic   last;
    entry_t ent;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    entry_t ent;
  } result_t;

endpackage

[rtl/core/rtrs_ram.sv]
// ----------------------------------------------------------------------------
// rtrs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/rtrs_front.sv]
// ----------------------------------------------------------------------------
// rtrs_front
// Configuration registers and rectangle hit classification of each point.
// ----------------------------------------------------------------------------
module rtrs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rtrs_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [rtrs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 push,
  input  logic [rtrs_pkg::ID_W-1:0]            point_id,
  input  logic [rtrs_pkg::RANK_W-1:0]          point_rank,
  input  logic [rtrs_pkg::CRD_W-1:0]           point_x,
  input  logic [rtrs_pkg::CRD_W-1:0]           point_y,
  input  logic                                 is_last_point,
  input  rtrs_pkg::q_stat_t                    q_stat,
  output logic                                 q_push,
  output rtrs_pkg::item_t                      q_item,
  output logic [rtrs_pkg::CNT_W-1:0]           cap
);

  logic signed [rtrs_pkg::CRD_W-1:0] low_x_r, high_x_r, low_y_r, high_y_r;
  logic [rtrs_pkg::KEEP_W-1:0]       keep_r;
  logic [rtrs_pkg::MODE_W-1:0]       mode_r;
  logic                              hx, hy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_x_r  <= {1'b1, {(rtrs_pkg::CRD_W-1){1'b0}}};
      high_x_r <= {1'b0, {(rtrs_pkg::CRD_W-1){1'b1}}};
      low_y_r  <= {1'b1, {(rtrs_pkg::CRD_W-1){1'b0}}};
      high_y_r <= {1'b0, {(rtrs_pkg::CRD_W-1){1'b1}}};
      keep_r   <= rtrs_pkg::KEEP_RESET;
      mode_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        rtrs_pkg::REG_LOW_X:    low_x_r  <= cfg_data[rtrs_pkg::CRD_W-1:0];
        rtrs_pkg::REG_HIGH_X:   high_x_r <= cfg_data[rtrs_pkg::CRD_W-1:0];
        rtrs_pkg::REG_LOW_Y:    low_y_r  <= cfg_data[rtrs_pkg::CRD_W-1:0];
        rtrs_pkg::REG_HIGH_Y:   high_y_r <= cfg_data[rtrs_pkg::CRD_W-1:0];
        rtrs_pkg::REG_KEEP_CNT: keep_r   <= cfg_data[rtrs_pkg::KEEP_W-1:0];
        rtrs_pkg::REG_HIT_MODE: mode_r   <= cfg_data[rtrs_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign hx = ($signed(point_x) >= low_x_r) && ($signed(point_x) <= high_x_r);
  assign hy = ($signed(point_y) >= low_y_r) && ($signed(point_y) <= high_y_r);

  always_comb begin
    case (mode_r)
      rtrs_pkg::MODE_X_ONLY: q_item.hit = hx;
      rtrs_pkg::MODE_Y_ONLY: q_item.hit = hy;
      default:               q_item.hit = hx && hy;
    endcase
    q_item.last     = is_last_point;
    q_item.ent.id   = point_id;
    q_item.ent.rank = point_rank;
    q_item.ent.x    = point_x;
    q_item.ent.y    = point_y;
  end

  assign q_push = push && !q_stat.full;

  always_comb begin
    if (int'(keep_r) > rtrs_pkg::MAX_KEEP) begin
      cap = rtrs_pkg::CNT_W'(rtrs_pkg::MAX_KEEP);
    end else begin
      cap = rtrs_pkg::CNT_W'(keep_r);
    end
  end

endmodule

[rtl/core/rtrs_queue.sv]
// ----------------------------------------------------------------------------
// rtrs_queue
// Two-entry queue of classified points between front and back.
// ----------------------------------------------------------------------------
module rtrs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rtrs_pkg::item_t   push_item,
  input  logic              pop,
  output rtrs_pkg::item_t   head,
  output rtrs_pkg::q_stat_t stat
);

  rtrs_pkg::item_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/core/rtrs_back.sv]
// ----------------------------------------------------------------------------
// rtrs_back
// Keeps the lowest-rank hits in a RAM, rescans the worst entry after a
// replacement and emits the kept set in ascending rank by selection passes.
// ----------------------------------------------------------------------------
module rtrs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rtrs_pkg::item_t            head,
  input  rtrs_pkg::q_stat_t          q_stat,
  output logic                       q_pop,
  input  logic [rtrs_pkg::CNT_W-1:0] cap,
  output rtrs_pkg::result_t          res,
  output logic                       res_vld,
  input  logic                       res_pop
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_SORT = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_NONE = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic                          last_r, last_nxt;
  logic [rtrs_pkg::CNT_W-1:0]    total_r, total_nxt;
  logic                          wok_r, wok_nxt;
  logic [rtrs_pkg::RANK_W-1:0]   wrank_r, wrank_nxt;
  logic [rtrs_pkg::SLOT_W-1:0]   wslot_r, wslot_nxt;
  logic [rtrs_pkg::CNT_W-1:0]    ptr_r, ptr_nxt;
  logic                          cmp_vld_r, cmp_vld_nxt;
  logic [rtrs_pkg::SLOT_W-1:0]   cmp_slot_r, cmp_slot_nxt;
  logic                          bok_r, bok_nxt;
  logic [rtrs_pkg::SLOT_W-1:0]   bslot_r, bslot_nxt;
  rtrs_pkg::entry_t              bent_r, bent_nxt;
  logic                          pok_r, pok_nxt;
  logic [rtrs_pkg::RANK_W-1:0]   prank_r, prank_nxt;
  logic [rtrs_pkg::SLOT_W-1:0]   pslot_r, pslot_nxt;
  logic [rtrs_pkg::CNT_W-1:0]    ecnt_r, ecnt_nxt;
  rtrs_pkg::result_t             res_r, res_nxt;
  logic                          rvld_r, rvld_nxt;

  logic                          we;
  logic [rtrs_pkg::SLOT_W-1:0]   waddr;
  rtrs_pkg::entry_t              rd_ent;
  logic [rtrs_pkg::ENTRY_W-1:0]  rdata;
  logic                          out_free, go_sort, qual, scan_done;

  rtrs_ram #(
    .WIDTH (rtrs_pkg::ENTRY_W),
    .DEPTH (rtrs_pkg::MAX_KEEP)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (head.ent),
    .raddr (ptr_r[rtrs_pkg::SLOT_W-1:0]),
    .rdata (rdata)
  );

  assign rd_ent    = rdata;
  assign out_free  = !rvld_r || res_pop;
  assign scan_done = (ptr_r >= total_r) && !cmp_vld_r;
  assign qual      = !pok_r || (rd_ent.rank > prank_r) ||
                     ((rd_ent.rank == prank_r) && (cmp_slot_r > pslot_r));

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    total_nxt    = total_r;
    wok_nxt      = wok_r;
    wrank_nxt    = wrank_r;
    wslot_nxt    = wslot_r;
    ptr_nxt      = ptr_r;
    cmp_vld_nxt  = 1'b0;
    cmp_slot_nxt = cmp_slot_r;
    bok_nxt      = bok_r;
    bslot_nxt    = bslot_r;
    bent_nxt     = bent_r;
    pok_nxt      = pok_r;
    prank_nxt    = prank_r;
    pslot_nxt    = pslot_r;
    ecnt_nxt     = ecnt_r;
    res_nxt      = res_r;
    rvld_nxt     = rvld_r && !res_pop;
    we           = 1'b0;
    waddr        = total_r[rtrs_pkg::SLOT_W-1:0];
    q_pop        = 1'b0;
    go_sort      = 1'b0;

    // sequential read sweep shared by rescan and selection
    if ((state_r == ST_SCAN) || (state_r == ST_SORT)) begin
      if (ptr_r < total_r) begin
        ptr_nxt      = ptr_r + 1'b1;
        cmp_vld_nxt  = 1'b1;
        cmp_slot_nxt = ptr_r[rtrs_pkg::SLOT_W-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop    = 1'b1;
          last_nxt = head.last;
          go_sort  = head.last;
          if (head.hit) begin
            if (total_r < cap) begin
              we = 1'b1;
              if (!wok_r || (head.ent.rank > wrank_r)) begin
                wok_nxt   = 1'b1;
                wrank_nxt = head.ent.rank;
                wslot_nxt = total_r[rtrs_pkg::SLOT_W-1:0];
              end
              total_nxt = total_r + 1'b1;
            end else if ((total_r != '0) && wok_r && (head.ent.rank <= wrank_r)) begin
              we        = 1'b1;
              waddr     = wslot_r;
              wok_nxt   = 1'b0;
              wslot_nxt = '0;
              ptr_nxt   = '0;
              go_sort   = 1'b0;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (cmp_vld_r && (!wok_r || (rd_ent.rank > wrank_r))) begin
          wok_nxt   = 1'b1;
          wrank_nxt = rd_ent.rank;
          wslot_nxt = cmp_slot_r;
        end
        if (scan_done) begin
          state_nxt = ST_IDLE;
          go_sort   = last_r;
        end
      end
      ST_SORT: begin
        if (cmp_vld_r && qual && (!bok_r || (rd_ent.rank < bent_r.rank))) begin
          bok_nxt   = 1'b1;
          bslot_nxt = cmp_slot_r;
          bent_nxt  = rd_ent;
        end
        if (scan_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          rvld_nxt      = 1'b1;
          res_nxt.valid = 1'b1;
          res_nxt.last  = ((ecnt_r + 1'b1) == total_r);
          res_nxt.ent   = bent_r;
          pok_nxt       = 1'b1;
          prank_nxt     = bent_r.rank;
          pslot_nxt     = bslot_r;
          ecnt_nxt      = ecnt_r + 1'b1;
          ptr_nxt       = '0;
          bok_nxt       = 1'b0;
          if ((ecnt_r + 1'b1) == total_r) begin
            total_nxt = '0;
            wok_nxt   = 1'b0;
            wslot_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SORT;
          end
        end
      end
      ST_NONE: begin
        if (out_free) begin
          rvld_nxt      = 1'b1;
          res_nxt.valid = 1'b0;
          res_nxt.last  = 1'b1;
          res_nxt.ent   = '0;
          total_nxt     = '0;
          wok_nxt       = 1'b0;
          wslot_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (go_sort) begin
      ptr_nxt  = '0;
      bok_nxt  = 1'b0;
      pok_nxt  = 1'b0;
      ecnt_nxt = '0;
      if (total_nxt == '0) begin
        state_nxt = ST_NONE;
      end else begin
        state_nxt = ST_SORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      total_r   <= '0;
      wok_r     <= 1'b0;
      wslot_r   <= '0;
      ptr_r     <= '0;
      cmp_vld_r <= 1'b0;
      bok_r     <= 1'b0;
      pok_r     <= 1'b0;
      ecnt_r    <= '0;
      rvld_r    <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      wok_r     <= wok_nxt;
      wslot_r   <= wslot_nxt;
      ptr_r     <= ptr_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      bok_r     <= bok_nxt;
      pok_r     <= pok_nxt;
      ecnt_r    <= ecnt_nxt;
      rvld_r    <= rvld_nxt;
      last_r    <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wrank_r    <= wrank_nxt;
    cmp_slot_r <= cmp_slot_nxt;
    bslot_r    <= bslot_nxt;
    bent_r     <= bent_nxt;
    prank_r    <= prank_nxt;
    pslot_r    <= pslot_nxt;
    res_r      <= res_nxt;
  end

  assign res     = res_r;
  assign res_vld = rvld_r;

endmodule

[rtl/core/rect_topk_rank_select.sv]
// ----------------------------------------------------------------------------
// rect_topk_rank_select
// Keeps the lowest-rank points that hit a rectangle or one of its axis ranges and returns them sorted.
// ----------------------------------------------------------------------------
// Back end: a point that is kept or missed is taken while idle; a replacement
//   adds a rescan of the RAM before the next point is taken.
// Output: on the last point, n kept results come out through n selection
//   passes over the RAM read port; none kept gives a single invalid result.
// Reset: synchronous, active low; clears control state and the selection,
//   and sets the registers to their defaults. The RAM is not cleared.
module rect_topk_rank_select (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rtrs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [rtrs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic signed [rtrs_pkg::ID_W-1:0]   in_point_id,
  input  logic [rtrs_pkg::RANK_W-1:0]        in_point_rank,
  input  logic signed [rtrs_pkg::CRD_W-1:0]  in_point_x,
  input  logic signed [rtrs_pkg::CRD_W-1:0]  in_point_y,
  input  logic                               in_is_last_point,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [rtrs_pkg::ID_W-1:0]   out_id,
  output logic [rtrs_pkg::RANK_W-1:0]        out_rank,
  output logic signed [rtrs_pkg::CRD_W-1:0]  out_x,
  output logic signed [rtrs_pkg::CRD_W-1:0]  out_y,
  output logic                               out_valid,
  output logic                               out_last
);

  logic                       q_push, q_pop, res_vld;
  rtrs_pkg::item_t            q_item, head;
  rtrs_pkg::q_stat_t          q_stat;
  rtrs_pkg::result_t          res;
  logic [rtrs_pkg::CNT_W-1:0] cap;

  rtrs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .push          (in_push),
    .point_id      (in_point_id),
    .point_rank    (in_point_rank),
    .point_x       (in_point_x),
    .point_y       (in_point_y),
    .is_last_point (in_is_last_point),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_item        (q_item),
    .cap           (cap)
  );

  rtrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (head),
    .stat      (q_stat)
  );

  rtrs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .cap     (cap),
    .res     (res),
    .res_vld (res_vld),
    .res_pop (out_pop)
  );

  assign in_full   = q_stat.full;
  assign out_empty = !res_vld;
  assign out_id    = res.ent.id;
  assign out_rank  = res.ent.rank;
  assign out_x     = res.ent.x;
  assign out_y     = res.ent.y;
  assign out_valid = res.valid;
  assign out_last  = res.last;

endmodule

[verif/rect_topk_rank_select_test.sv]
// ----------------------------------------------------------------------------
// rect_topk_rank_select_test
// Streams point queries into the rank selector and checks every returned
// point against a local top-k model, with random stalls on both queues.
// ----------------------------------------------------------------------------
module rect_topk_rank_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] id;
    logic [30:0] rank;
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } point_t;

  typedef struct {
    logic [31:0] id;
    logic [30:0] rank;
    logic [31:0] x;
    logic [31:0] y;
    logic        valid;
    logic        last;
  } sel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rtrs_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [rtrs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [31:0] in_point_id = '0;
  logic [30:0] in_point_rank = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic in_is_last_point = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [31:0] out_id;
  logic [30:0] out_rank;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic out_valid;
  logic out_last;

  rect_topk_rank_select DUT (.*);

  always #5 clk = ~clk;

  // selector model
  logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
  logic [5:0] keep_cnt;
  logic [1:0] mode;
  point_t kept [rtrs_pkg::MAX_KEEP];
  int kept_n;
  sel_t sel_q[$];

  int errors = 0;
  int n_results = 0;
  int n_points = 0;
  int n_queries = 0;
  int cycles = 0;
  bit quiet = 0;
  localparam int CYCLE_LIMIT = 600000;

  function automatic bit is_hit(point_t p);
    bit hx, hy;
    hx = $signed(p.x) >= lo_x && $signed(p.x) <= hi_x;
    hy = $signed(p.y) >= lo_y && $signed(p.y) <= hi_y;
    if (mode == rtrs_pkg::MODE_X_ONLY) return hx;
    if (mode == rtrs_pkg::MODE_Y_ONLY) return hy;
    return hx && hy;
  endfunction

  task automatic predict_select(point_t p);
    int cap, worst, ws, n;
    int order[rtrs_pkg::MAX_KEEP];
    sel_t r;
    cap = keep_cnt > rtrs_pkg::MAX_KEEP ? rtrs_pkg::MAX_KEEP : keep_cnt;
    if (is_hit(p)) begin
      if (kept_n < cap) begin
        kept[kept_n] = p;
        kept_n++;
      end else if (kept_n > 0) begin
        worst = -1;
        ws = 0;
        for (int j = 0; j < kept_n; j++)
          if (int'(kept[j].rank) > worst) begin
            worst = kept[j].rank;
            ws = j;
          end
        if (int'(p.rank) <= worst) kept[ws] = p;
      end
    end
    if (!p.last) return;
    n = kept_n;
    if (n == 0) begin
      r = '{default: '0};
      r.last = 1'b1;
      sel_q.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        int j;
        j = i;
        while (j > 0 && kept[order[j-1]].rank > kept[i].rank) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      for (int i = 0; i < n; i++) begin
        r.id = kept[order[i]].id;
        r.rank = kept[order[i]].rank;
        r.x = kept[order[i]].x;
        r.y = kept[order[i]].y;
        r.valid = 1'b1;
        r.last = (i == n - 1);
        sel_q.push_back(r);
      end
    end
    kept_n = 0;
  endtask

  task automatic write_reg(logic [rtrs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rtrs_pkg::REG_LOW_X: lo_x = val;
      rtrs_pkg::REG_HIGH_X: hi_x = val;
      rtrs_pkg::REG_LOW_Y: lo_y = val;
      rtrs_pkg::REG_HIGH_Y: hi_y = val;
      rtrs_pkg::REG_KEEP_CNT: keep_cnt = val[5:0];
      rtrs_pkg::REG_HIT_MODE: mode = val[1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain_wait();
    while (sel_q.size() != 0) @(negedge clk);
    repeat (rtrs_pkg::MAX_KEEP * (rtrs_pkg::MAX_KEEP + 3) + 50) @(negedge clk);
  endtask

  // leaves in_push high; the caller drops it after the last point
  task automatic push_point(point_t p, bit typed);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_point_id <= p.id;
    in_point_rank <= p.rank;
    in_point_x <= p.x;
    in_point_y <= p.y;
    in_is_last_point <= p.last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (!typed) predict_select(p);
    n_points++;
    if (p.last) n_queries++;
    @(negedge clk);
  endtask

  // result side: random stall bursts
  always @(negedge clk) begin
    if (!quiet && $urandom_range(0, 4) == 0) begin
      out_pop <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_pop && !out_empty) begin
      if (sel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: id %h rank %h", out_id, out_rank);
      end else begin
        sel_t e;
        e = sel_q.pop_front();
        n_results++;
        if (out_id !== e.id || out_rank !== e.rank || out_x !== e.x || out_y !== e.y ||
            out_valid !== e.valid || out_last !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp id %h rank %h x %h y %h v %b l %b, got %h %h %h %h %b %b",
                     e.id, e.rank, e.x, e.y, e.valid, e.last,
                     out_id, out_rank, out_x, out_y, out_valid, out_last);
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("rect_topk_rank_select_test: done, errors");
      $finish;
    end
  end

  function automatic point_t rand_point(bit last);
    point_t p;
    p.id = $urandom;
    p.rank = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 40));
    p.x = ($urandom_range(0, 1)) ? 32'($urandom) : 32'(int'($urandom_range(0, 200)) - 100);
    p.y = ($urandom_range(0, 1)) ? 32'($urandom) : 32'(int'($urandom_range(0, 200)) - 100);
    p.last = last;
    return p;
  endfunction

  typedef struct {
    logic [31:0] id;
    logic [30:0] rank;
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
    bit          typed;
    sel_t        want;
  } row_t;

  row_t plan[$];

  initial begin
    point_t p;
    lo_x = 32'h8000_0000; hi_x = 32'h7fff_ffff;
    lo_y = 32'h8000_0000; hi_y = 32'h7fff_ffff;
    keep_cnt = rtrs_pkg::KEEP_RESET; mode = 2'd0; kept_n = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table at reset defaults
    plan.push_back('{32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1, 1,
                     '{32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1, 1}});
    plan.push_back('{32'h8000_0000, 31'd0, 32'h7fff_ffff, 32'h8000_0000, 1, 1,
                     '{32'h8000_0000, 31'd0, 32'h7fff_ffff, 32'h8000_0000, 1, 1}});
    plan.push_back('{32'd1, 31'd5, 32'd0, 32'd0, 0, 0, '{default: '0}});
    plan.push_back('{32'd2, 31'd5, 32'd1, 32'd1, 0, 0, '{default: '0}});
    plan.push_back('{32'd3, 31'd2, 32'hffff_ffff, 32'd3, 1, 0, '{default: '0}});
    foreach (plan[i]) begin
      if (plan[i].typed) sel_q.push_back(plan[i].want);
      p = '{plan[i].id, plan[i].rank, plan[i].x, plan[i].y, plan[i].last};
      push_point(p, plan[i].typed);
    end
    in_push <= 1'b0;
    drain_wait();

    // empty rectangle: single no-hit result
    write_reg(rtrs_pkg::REG_LOW_X, 32'd10);
    write_reg(rtrs_pkg::REG_HIGH_X, 32'd5);
    sel_q.push_back('{32'd0, 31'd0, 32'd0, 32'd0, 1'b0, 1'b1});
    in_push <= 1'b1; in_point_id <= 32'd9; in_point_rank <= 31'd1;
    in_point_x <= 32'd7; in_point_y <= 32'd0; in_is_last_point <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    n_points++; n_queries++;
    @(negedge clk);
    in_push <= 1'b0;
    drain_wait();

    // configuration phases, random queries
    for (int ph = 0; ph < 8; ph++) begin
      int bx, by;
      bx = int'($urandom_range(0, 100)) - 50;
      by = int'($urandom_range(0, 100)) - 50;
      write_reg(rtrs_pkg::REG_LOW_X, ph == 7 ? 32'h8000_0000 : 32'(bx - 30));
      write_reg(rtrs_pkg::REG_HIGH_X, ph == 7 ? 32'h7fff_ffff : 32'(bx + 30));
      write_reg(rtrs_pkg::REG_LOW_Y, ph == 6 ? 32'h7fff_ffff : 32'(by - 30));
      write_reg(rtrs_pkg::REG_HIGH_Y, ph == 6 ? 32'h8000_0000 : 32'(by + 30));
      case (ph)
        0: write_reg(rtrs_pkg::REG_KEEP_CNT, 32'd0);
        1: write_reg(rtrs_pkg::REG_KEEP_CNT, 32'd63);
        2: write_reg(rtrs_pkg::REG_KEEP_CNT, 32'd32);
        3: write_reg(rtrs_pkg::REG_KEEP_CNT, 32'd1);
        default: write_reg(rtrs_pkg::REG_KEEP_CNT, 32'($urandom_range(1, 6)));
      endcase
      write_reg(rtrs_pkg::REG_HIT_MODE, 32'(ph % 4));
      quiet = (ph == 7);
      for (int q = 0; q < 3; q++) begin
        int len;
        len = (ph == 1 && q == 0) ? 40 : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) push_point(rand_point(k == len - 1), 1'b0);
      end
      in_push <= 1'b0;
      drain_wait();
    end

    $display("covered %0d points in %0d queries, %0d results checked",
             n_points, n_queries, n_results);
    if (errors == 0 && sel_q.size() == 0) begin
      $display("rect_topk_rank_select_test: done, clean");
    end else begin
      $display("rect_topk_rank_select_test: done, errors");
    end
    $finish;
  end
endmodule
